// ----- hw/rtl/standard_map_iterator_defines.svh -----
// Assertion helpers for the iterator RTL, used by the sequencer.
// Each macro expands to one labeled concurrent assertion on the rising
// clock edge, disabled while reset is asserted.
`ifndef STANDARD_MAP_ITERATOR_DEFINES_SVH
`define STANDARD_MAP_ITERATOR_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define SMI_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define SMI_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/smi_pkg.sv -----
package smi_pkg;

  // Phase and table geometry.
  localparam int PHASE_BITS     = 16;
  localparam int SINE_ADDR_BITS = 10;
  localparam int QUAD_OFF_BITS  = SINE_ADDR_BITS - 2;
  localparam int QLEN           = 1 << QUAD_OFF_BITS;
  localparam int U_SHIFT        = 17 - SINE_ADDR_BITS;

  // Sine magnitude is Q1.15 clamped to 0..32767, so 15 bits.
  localparam int SINE_BITS     = 15;
  localparam int SINE_ROM_BITS = QLEN * SINE_BITS;

  // Kick strength register, unsigned Q4.12.
  localparam int                KICK_BITS  = 16;
  localparam logic [KICK_BITS-1:0] KICK_RESET = KICK_BITS'(4096);

  // Scaling by 1/(2*pi) in Q16 and the final rounding shift.
  localparam int INV_BITS   = 14;
  localparam logic [INV_BITS-1:0] INV_TWO_PI = INV_BITS'(10430);
  localparam int KICK_SHIFT = 43 - PHASE_BITS;
  localparam int PROD1_BITS = SINE_BITS + KICK_BITS;
  localparam int PROD2_BITS = PROD1_BITS + INV_BITS;

  // Operation codes carried in the op bit of an input transaction.
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Polynomial coefficients of the quarter sine, Q30.
  localparam longint SINE_C0 = 172272;
  localparam longint SINE_C1 = -5026988;
  localparam longint SINE_C2 = 85569304;
  localparam longint SINE_C3 = -693598667;
  localparam longint SINE_C4 = 1686629713;

  // Input and result transactions.
  typedef struct packed {
    logic                  op;
    logic [PHASE_BITS-1:0] start_angle;
    logic [PHASE_BITS-1:0] start_momentum;
  } in_item_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] angle_out;
    logic [PHASE_BITS-1:0] momentum_out;
    logic                  from_load;
  } out_item_t;

  // Microprogram step addresses.
  typedef enum logic [2:0] {
    ST_IDLE  = 3'd0,
    ST_SINE  = 3'd1,
    ST_MUL1  = 3'd2,
    ST_MUL2  = 3'd3,
    ST_KICK  = 3'd4,
    ST_DRIFT = 3'd5,
    ST_LOAD  = 3'd6
  } step_t;

  // One control word of the microprogram.
  typedef struct packed {
    logic  dispatch;   // wait for a transaction, branch on its op
    logic  sine_en;
    logic  mul1_en;
    logic  mul2_en;
    logic  kick_en;
    logic  drift_en;
    logic  emit;       // hold here until the result register is free
    logic  from_load;
    step_t next;
  } ucode_t;

  // Datapath strobes produced by the sequencer.
  typedef struct packed {
    logic load_en;
    logic sine_en;
    logic mul1_en;
    logic mul2_en;
    logic kick_en;
    logic drift_en;
    logic emit_fire;
    logic from_load;
  } ctl_t;

  // Microprogram store.
  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    w = '0;
    w.next = ST_IDLE;
    case (step)
      ST_IDLE: begin
        w.dispatch = 1'b1;
      end
      ST_SINE: begin
        w.sine_en = 1'b1;
        w.next    = ST_MUL1;
      end
      ST_MUL1: begin
        w.mul1_en = 1'b1;
        w.next    = ST_MUL2;
      end
      ST_MUL2: begin
        w.mul2_en = 1'b1;
        w.next    = ST_KICK;
      end
      ST_KICK: begin
        w.kick_en = 1'b1;
        w.next    = ST_DRIFT;
      end
      ST_DRIFT: begin
        w.drift_en = 1'b1;
        w.emit     = 1'b1;
      end
      ST_LOAD: begin
        w.emit      = 1'b1;
        w.from_load = 1'b1;
      end
      default: begin
        w.next = ST_IDLE;
      end
    endcase
    return w;
  endfunction

  // sin(pi/2 * u) in Q1.15 for u in Q1.15, evaluated at elaboration.
  function automatic logic [SINE_BITS-1:0] quarter_sine(input longint u);
    longint z;
    longint acc;
    z   = (u * u) / 32768;
    acc = SINE_C0;
    acc = SINE_C1 + (acc * z) / 32768;
    acc = SINE_C2 + (acc * z) / 32768;
    acc = SINE_C3 + (acc * z) / 32768;
    acc = SINE_C4 + (acc * z) / 32768;
    acc = (acc * u) / 32768;
    acc = (acc + 16384) / 32768;
    if (acc < 0) acc = 0;
    if (acc > 32767) acc = 32767;
    return acc[SINE_BITS-1:0];
  endfunction

  // Quarter-wave table, entry t at bits [t*SINE_BITS +: SINE_BITS].
  function automatic logic [SINE_ROM_BITS-1:0] build_sine_rom();
    logic [SINE_ROM_BITS-1:0] rom;
    rom = '0;
    for (int t = 0; t < QLEN; t++) begin
      rom[t*SINE_BITS +: SINE_BITS] = quarter_sine(longint'(t) << U_SHIFT);
    end
    return rom;
  endfunction

  localparam logic [SINE_ROM_BITS-1:0] SINE_ROM  = build_sine_rom();
  // Value at the quarter-turn point, one past the table.
  localparam logic [SINE_BITS-1:0]     SINE_PEAK = quarter_sine(longint'(QLEN) << U_SHIFT);

  // Angle to table index, truncated or zero filled.
  function automatic logic [SINE_ADDR_BITS-1:0] phase_to_index(
      input logic [PHASE_BITS-1:0] angle);
    logic [PHASE_BITS+SINE_ADDR_BITS-1:0] wide;
    wide = {angle, {SINE_ADDR_BITS{1'b0}}};
    return wide[PHASE_BITS+SINE_ADDR_BITS-1 -: SINE_ADDR_BITS];
  endfunction

endpackage

// ----- hw/rtl/smi_seq.sv -----
`include "standard_map_iterator_defines.svh"

module smi_seq
  import smi_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic in_op,
  input  logic out_free,
  output logic in_stall,
  output ctl_t ctl
);

  step_t  step_r;
  step_t  step_nxt;
  ucode_t cw;
  logic   take;

  // Fetch the control word for the current step.
  assign cw       = ucode_rom(step_r);
  assign take     = cw.dispatch & in_valid;
  assign in_stall = ~cw.dispatch;

  // Step counter with the dispatch branch and the emit hold.
  always_comb begin
    step_nxt = cw.next;
    if (cw.dispatch) begin
      if (!in_valid) begin
        step_nxt = ST_IDLE;
      end else if (in_op == OP_STEP) begin
        step_nxt = ST_SINE;
      end else begin
        step_nxt = ST_LOAD;
      end
    end else if (cw.emit && !out_free) begin
      step_nxt = step_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= ST_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

  // Datapath strobes; the drift and the emit wait for a free result register.
  always_comb begin
    ctl           = '0;
    ctl.load_en   = take & (in_op == OP_LOAD);
    ctl.sine_en   = cw.sine_en;
    ctl.mul1_en   = cw.mul1_en;
    ctl.mul2_en   = cw.mul2_en;
    ctl.kick_en   = cw.kick_en;
    ctl.drift_en  = cw.drift_en & out_free;
    ctl.emit_fire = cw.emit & out_free;
    ctl.from_load = cw.from_load;
  end

  `SMI_ASSERT_SAME(a_take_only_idle, in_valid && !in_stall, step_r == ST_IDLE, "take not in idle")
  `SMI_ASSERT_NEXT(a_mul2_then_kick, step_r == ST_MUL2, step_r == ST_KICK, "no kick after mul2")
  `SMI_ASSERT_NEXT(a_emit_returns, ctl.emit_fire, step_r == ST_IDLE, "no idle after emit")

endmodule

// ----- hw/rtl/smi_dp.sv -----
module smi_dp
  import smi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  ctl_t                 ctl,
  input  in_item_t             in_data,
  input  logic                 cfg_we,
  input  logic [KICK_BITS-1:0] cfg_wdata,
  input  logic                 out_stall,
  output logic                 out_valid,
  output out_item_t            out_data
);

  localparam logic [PHASE_BITS-1:0]      HALF_TURN = {1'b1, {(PHASE_BITS-1){1'b0}}};
  localparam logic [QUAD_OFF_BITS:0]     QLEN_V    = (QUAD_OFF_BITS+1)'(QLEN);
  localparam logic [PROD2_BITS:0]        ROUND_ADD = (PROD2_BITS+1)'(1) << (KICK_SHIFT - 1);

  logic [KICK_BITS-1:0]  kick_r;
  logic [PHASE_BITS-1:0] angle_r;
  logic [PHASE_BITS-1:0] angle_nxt;
  logic [PHASE_BITS-1:0] momentum_r;
  logic [PHASE_BITS-1:0] momentum_nxt;
  logic [SINE_BITS-1:0]  sine_mag_r;
  logic                  sine_neg_r;
  logic [PROD1_BITS-1:0] prod1_r;
  logic [PROD2_BITS-1:0] prod2_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;

  logic [SINE_ADDR_BITS-1:0] idx;
  logic [1:0]                quad;
  logic [QUAD_OFF_BITS:0]    offs;
  logic [SINE_BITS-1:0]      sine_mag;
  logic [PROD2_BITS:0]       rounded;
  logic [PHASE_BITS-1:0]     kick_mag;
  logic [PHASE_BITS-1:0]     kick_val;

  // Kick strength register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kick_r <= KICK_RESET;
    end else if (cfg_we) begin
      kick_r <= cfg_wdata;
    end
  end

  // Quarter-wave lookup, mirrored in the odd quadrants.
  always_comb begin
    idx  = phase_to_index(angle_r);
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    offs = {1'b0, idx[QUAD_OFF_BITS-1:0]};
    if (quad[0]) begin
      offs = QLEN_V - offs;
    end
    if (offs[QUAD_OFF_BITS]) begin
      sine_mag = SINE_PEAK;
    end else begin
      sine_mag = SINE_ROM[offs[QUAD_OFF_BITS-1:0]*SINE_BITS +: SINE_BITS];
    end
  end

  // Kick magnitude rounded half away from zero, then signed and wrapped.
  always_comb begin
    rounded  = {1'b0, prod2_r} + ROUND_ADD;
    kick_mag = rounded[KICK_SHIFT +: PHASE_BITS];
    kick_val = sine_neg_r ? (PHASE_BITS'(0) - kick_mag) : kick_mag;
  end

  assign momentum_nxt = momentum_r + kick_val;
  assign angle_nxt    = angle_r + momentum_r + HALF_TURN;

  // Arithmetic pipeline registers for the table read and the two multiplies.
  always_ff @(posedge clk) begin
    if (ctl.sine_en) begin
      sine_mag_r <= sine_mag;
      sine_neg_r <= quad[1];
    end
    if (ctl.mul1_en) begin
      prod1_r <= PROD1_BITS'(sine_mag_r) * PROD1_BITS'(kick_r);
    end
    if (ctl.mul2_en) begin
      prod2_r <= PROD2_BITS'(prod1_r) * PROD2_BITS'(INV_TWO_PI);
    end
  end

  // Orbit state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r    <= '0;
      momentum_r <= '0;
    end else if (ctl.load_en) begin
      angle_r    <= in_data.start_angle;
      momentum_r <= in_data.start_momentum;
    end else begin
      if (ctl.kick_en) begin
        momentum_r <= momentum_nxt;
      end
      if (ctl.drift_en) begin
        angle_r <= angle_nxt;
      end
    end
  end

  // Result register; the drift result is captured as it is computed.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.emit_fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.emit_fire) begin
      out_data_r.angle_out    <= ctl.drift_en ? angle_nxt : angle_r;
      out_data_r.momentum_out <= momentum_r;
      out_data_r.from_load    <= ctl.from_load;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hw/rtl/standard_map_iterator.sv -----
// Standard map iterator for one orbit; angle and momentum are fractions
// of a full turn, so both wrap modulo the word width.
// Input channel in_valid/in_stall/in_data: op 0 loads a start point and
// echoes it, op 1 advances the orbit by one kick and one drift.
// Result channel out_valid/out_stall/out_data: one transaction per input.
// cfg_we/cfg_wdata write the kick strength K (Q4.12); write it only idle.
// After acceptance a load runs its load step and an iteration runs the
// microprogram's table read, two multiplies, the kick and the drift; the
// result is registered at the emit step. One transaction is in work at a
// time, so a new one is taken only after the last result has been emitted.
// A new transaction is taken while an earlier result still waits in the
// result register; the emit step holds until that register is free.
// A stalled result holds its value. Reset (rst_n low, synchronous) clears
// the orbit to zero, sets K to 1.0 and empties the result register.
module standard_map_iterator
  import smi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_we,
  input  logic [KICK_BITS-1:0] cfg_wdata
);

  ctl_t ctl;
  logic out_free;

  // The result register can take a new result when empty or being read.
  assign out_free = ~out_valid | ~out_stall;

  smi_seq u_seq (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_op    (in_data.op),
    .out_free (out_free),
    .in_stall (in_stall),
    .ctl      (ctl)
  );

  smi_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ----- tb/sv/tb.sv -----
module tb;
  import smi_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Quarter-sine polynomial, Q30, highest power first.
  localparam longint SINE_POLY [5] = '{
    172272, -5026988, 85569304, -693598667, 1686629713
  };
  localparam longint INV_TWO_PI_Q16 = 10430;
  localparam int     KICK_ROUND_SHIFT = 43 - PHASE_BITS;
  localparam int     NUM_PHASES = 8;
  localparam int     ITEMS_PER_PHASE = 178;
  localparam int     CYCLE_LIMIT = 600000;

  typedef struct {
    in_item_t  stim;
    bit        known;
    out_item_t want;
  } stim_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;
  logic      cfg_we;
  logic [KICK_BITS-1:0] cfg_wdata;

  // Predictor state mirrors the orbit and the kick strength.
  logic [PHASE_BITS-1:0] orbit_ang;
  logic [PHASE_BITS-1:0] orbit_mom;
  logic [KICK_BITS-1:0]  kick_k;
  out_item_t             predicted_points [$];

  // Typed expectation for the directed row currently on the bus.
  bit        row_known = 1'b0;
  out_item_t row_want;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;

  stim_row_t directed_rows [$];

  standard_map_iterator dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Signed Q1.15 sine of an angle given in turns.
  function automatic longint sine_of_turn(input logic [PHASE_BITS-1:0] ang);
    logic [SINE_ADDR_BITS-1:0] idx;
    logic [1:0]                quad;
    longint                    t;
    longint                    u;
    longint                    z;
    longint                    acc;
    idx  = SINE_ADDR_BITS'(ang >> (PHASE_BITS - SINE_ADDR_BITS));
    quad = idx[SINE_ADDR_BITS-1 -: 2];
    t    = longint'(idx[SINE_ADDR_BITS-3:0]);
    // Odd quadrants run the quarter wave backwards.
    if (quad[0]) begin
      t = (longint'(1) << (SINE_ADDR_BITS - 2)) - t;
    end
    u   = t << (17 - SINE_ADDR_BITS);
    z   = (u * u) / 32768;
    acc = SINE_POLY[0];
    for (int i = 1; i < 5; i++) begin
      acc = SINE_POLY[i] + (acc * z) / 32768;
    end
    acc = (acc * u) / 32768;
    acc = (acc + 16384) / 32768;
    if (acc < 0) acc = 0;
    if (acc > 32767) acc = 32767;
    return quad[1] ? -acc : acc;
  endfunction

  // Applies one transaction to the predicted orbit and returns the point.
  function automatic out_item_t orbit_advance(input in_item_t it);
    out_item_t             pt;
    longint                s;
    longint                mag;
    logic [PHASE_BITS-1:0] kick;
    if (it.op == OP_LOAD) begin
      orbit_ang = it.start_angle;
      orbit_mom = it.start_momentum;
    end else begin
      s    = sine_of_turn(orbit_ang);
      mag  = (s < 0) ? -s : s;
      mag  = mag * longint'(kick_k) * INV_TWO_PI_Q16;
      kick = PHASE_BITS'((mag + (longint'(1) << (KICK_ROUND_SHIFT - 1))) >>> KICK_ROUND_SHIFT);
      if (s < 0) kick = -kick;
      // Kick uses the old angle, drift uses the new momentum.
      orbit_mom = orbit_mom + kick;
      orbit_ang = orbit_ang + orbit_mom + (PHASE_BITS'(1) << (PHASE_BITS - 1));
    end
    pt.angle_out    = orbit_ang;
    pt.momentum_out = orbit_mom;
    pt.from_load    = (it.op == OP_LOAD);
    return pt;
  endfunction

  task automatic note_error(input string msg);
    error_count++;
    if (error_count <= 10) $display("ERROR: %s", msg);
  endtask

  // Check results, then record accepted inputs and register writes.
  always @(posedge clk) begin : scoreboard
    out_item_t want;
    out_item_t got;
    if (!rst_n) begin
      orbit_ang = '0;
      orbit_mom = '0;
      kick_k    = KICK_RESET;
      predicted_points.delete();
    end else begin
      if (out_valid && !out_stall) begin
        got = out_data;
        if (predicted_points.size() == 0) begin
          note_error($sformatf("unexpected result angle=%h momentum=%h from_load=%b",
                               got.angle_out, got.momentum_out, got.from_load));
        end else begin
          want = predicted_points.pop_front();
          if (got.angle_out !== want.angle_out)
            note_error($sformatf("angle_out expected %h, got %h",
                                 want.angle_out, got.angle_out));
          if (got.momentum_out !== want.momentum_out)
            note_error($sformatf("momentum_out expected %h, got %h",
                                 want.momentum_out, got.momentum_out));
          if (got.from_load !== want.from_load)
            note_error($sformatf("from_load expected %b, got %b",
                                 want.from_load, got.from_load));
        end
      end
      if (cfg_we) kick_k = cfg_wdata;
      if (in_valid && !in_stall) begin
        want = orbit_advance(in_data);
        if (row_known) want = row_want;
        predicted_points.push_back(want);
      end
    end
  end

  // Receiver stalls at random according to the current phase.
  always @(negedge clk) begin
    out_stall <= rst_n && ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("standard_map_iterator regression: fail");
      $finish;
    end
  end

  // Offers one transaction and returns at the falling edge after it is taken.
  task automatic drive_item(input in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      in_data  <= in_item_t'({$urandom, $urandom});
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Waits until every predicted point has come out, then lets the block settle.
  task automatic drain_results();
    while (predicted_points.size() != 0) @(posedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic write_kick(input logic [KICK_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic add_row(input logic op, input logic [15:0] ang, input logic [15:0] mom,
                         input bit known, input logic [15:0] want_ang,
                         input logic [15:0] want_mom);
    stim_row_t r;
    r.stim.op             = op;
    r.stim.start_angle    = ang;
    r.stim.start_momentum = mom;
    r.known               = known;
    r.want.angle_out      = want_ang;
    r.want.momentum_out   = want_mom;
    r.want.from_load      = (op == OP_LOAD);
    directed_rows.push_back(r);
  endtask

  // Mostly orbit steps, with loads of a fresh start point at random.
  function automatic in_item_t orbit_item();
    in_item_t it;
    logic [15:0] corner [5];
    corner = '{16'h0000, 16'hFFFF, 16'h4000, 16'h8000, 16'hC000};
    it.start_angle    = PHASE_BITS'($urandom);
    it.start_momentum = PHASE_BITS'($urandom);
    it.op = ($urandom_range(99) < 12) ? OP_LOAD : OP_STEP;
    if (it.op == OP_LOAD && $urandom_range(4) == 0) begin
      it.start_angle    = corner[$urandom_range(4)];
      it.start_momentum = corner[$urandom_range(4)];
    end
    return it;
  endfunction

  initial begin : stimulus
    logic [KICK_BITS-1:0] kick_plan [NUM_PHASES];
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part under the reset kick strength of one.
    // A step from the reset point only drifts by half a turn; the start
    // fields of a step are ignored.
    add_row(OP_STEP, 16'hFFFF, 16'hFFFF, 1, 16'h8000, 16'h0000);
    add_row(OP_STEP, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'hFFFF, 16'hFFFF, 1, 16'hFFFF, 16'hFFFF);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h0000, 16'h0000, 1, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h4000, 16'h0000, 1, 16'h4000, 16'h0000);
    add_row(OP_STEP, 16'h1234, 16'h5678, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'hC000, 16'h8000, 1, 16'hC000, 16'h8000);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h2000, 16'h1234, 1, 16'h2000, 16'h1234);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h3FFF, 16'hFFFF, 1, 16'h3FFF, 16'hFFFF);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h8000, 16'h7FFF, 1, 16'h8000, 16'h7FFF);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'hAAAA, 16'h5555, 1, 16'hAAAA, 16'h5555);
    add_row(OP_STEP, 16'h5555, 16'hAAAA, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h5555, 16'hAAAA, 1, 16'h5555, 16'hAAAA);
    add_row(OP_STEP, 16'hAAAA, 16'h5555, 0, 16'h0000, 16'h0000);
    add_row(OP_LOAD, 16'h003F, 16'h0040, 1, 16'h003F, 16'h0040);
    add_row(OP_STEP, 16'h0000, 16'h0000, 0, 16'h0000, 16'h0000);

    foreach (directed_rows[i]) begin
      row_known = directed_rows[i].known;
      row_want  = directed_rows[i].want;
      drive_item(directed_rows[i].stim);
    end
    row_known = 1'b0;
    in_valid <= 1'b0;

    // Random phases, each with its own kick strength and idling mix.
    kick_plan = '{16'h0000, 16'hFFFF, 16'h1000, 16'h0000,
                  16'h0001, 16'h0000, 16'hFFFF, 16'h0000};
    kick_plan[3] = KICK_BITS'($urandom_range(65535));
    kick_plan[5] = KICK_BITS'($urandom_range(65535));
    kick_plan[7] = KICK_BITS'($urandom_range(65535));
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      // The block must be idle before its register is rewritten.
      drain_results();
      write_kick(kick_plan[ph]);
      case (ph % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 77;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 77;
        end
        default: begin
          send_idle_pct  = 26;
          recv_stall_pct = 26;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        drive_item(orbit_item());
      end
      in_valid <= 1'b0;
    end

    drain_results();
    repeat (12) @(posedge clk);
    if (error_count == 0) begin
      $display("standard_map_iterator regression: pass");
    end else begin
      $display("standard_map_iterator regression: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hw/rtl
hw/rtl/smi_pkg.sv
hw/rtl/smi_seq.sv
hw/rtl/smi_dp.sv
hw/rtl/standard_map_iterator.sv
tb/sv/tb.sv
